@@ rtl/core/twcom_pkg.sv @@
// Shared types, constants and arithmetic helpers for the trimmed center-of-mass block.
`timescale 1ns / 1ps
`default_nettype none
package twcom_pkg;

    localparam int MASS_W  = 24;
    localparam int COORD_W = 32;
    localparam int DIST_W  = 64;
    localparam int SUM_W   = 64;
    localparam int KF_W    = 17;
    localparam int EP_W    = 4;
    localparam int PASS_W  = 5;
    localparam int NCOORD  = 6;
    localparam int STEP_W  = 7;
    localparam int IN_W    = 216;
    localparam int OUT_W   = 200;

    localparam logic [KF_W-1:0] KF_ONE   = 17'h10000;
    localparam logic [KF_W-1:0] KF_RESET = 17'd58982;
    localparam logic [EP_W-1:0] EP_RESET = 4'd2;

    localparam logic CFG_KEEP_FRACTION = 1'b0;
    localparam logic CFG_EXTRA_PASSES  = 1'b1;

    localparam logic [STEP_W-1:0] STEPS_CENTER = 7'd64;
    localparam logic [STEP_W-1:0] STEPS_FRAC   = 7'd16;

    typedef struct packed {
        logic signed [COORD_W-1:0] vel_z;
        logic signed [COORD_W-1:0] vel_y;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_x;
        logic [MASS_W-1:0]         particle_mass;
    } particle_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [63:0]       rem_init;
        logic [63:0]       dividend;
        logic [63:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    function automatic logic signed [COORD_W-1:0] coord_sel(input particle_t p,
                                                            input logic [2:0] k);
        logic signed [COORD_W-1:0] r;
        case (k)
            3'd0: r = p.pos_x;
            3'd1: r = p.pos_y;
            3'd2: r = p.pos_z;
            3'd3: r = p.vel_x;
            3'd4: r = p.vel_y;
            default: r = p.vel_z;
        endcase
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                         input logic signed [SUM_W-1:0] b);
        logic signed [SUM_W-1:0] s;
        s = a + b;
        if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
            s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s;
    endfunction

    function automatic logic [DIST_W-1:0] sat_addu(input logic [DIST_W-1:0] a,
                                                   input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] sat32(input logic neg, input logic [63:0] q);
        logic [63:0] nq;
        logic [COORD_W-1:0] r;
        nq = -q;
        if (!neg) begin
            r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            r = (q > 64'h8000_0000) ? 32'h8000_0000 : nq[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/twcom_pstore.sv @@
// Particle store: one write port for loading, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module twcom_pstore #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire                  aclk,
    input  wire                  wr_en,
    input  wire [AW-1:0]         wr_addr,
    input  twcom_pkg::particle_t wr_data,
    input  wire                  rd_en,
    input  wire [AW-1:0]         rd_addr,
    output twcom_pkg::particle_t rd_data
);

    twcom_pkg::particle_t mem [DEPTH];
    twcom_pkg::particle_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/twcom_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module twcom_div (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  twcom_pkg::div_req_t req,
    output twcom_pkg::div_rsp_t rsp
);

    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dsr_reg;
    logic [twcom_pkg::STEP_W-1:0] left_reg;
    logic busy_reg;
    logic done_reg;
    logic [64:0] trial;
    logic [64:0] diff;
    logic ge;

    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= req.rem_init;
                quo_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
                left_reg <= req.steps;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[63:0] : trial[63:0];
                quo_reg  <= {quo_reg[62:0], ge};
                left_reg <= left_reg - 1'b1;
                if (left_reg == twcom_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule
`default_nettype wire

@@ rtl/core/trimmed_weighted_center_of_mass.sv @@
// Top level: particle loading, distance ranking and weighted center refinement.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid/s_tready    s_tdata particle, s_tlast last particle
//  m_       out        m_tvalid/m_tready    m_tdata center and passes
//  cfg_     in         cfg_we               cfg_index, cfg_data
//
// Particles load at one item per cycle. The item with s_tlast starts the work: the plain
// center, then per pass a ranking scan over the distance memory, a 16-step fraction divide
// for each kept particle nearer than the cut distance, and six 64-step center divides.
// Reset is synchronous; the stores need no clearing. A stalled result is held in the
// output register while the next set loads; the next result waits for it to leave.
`timescale 1ns / 1ps
`default_nettype none
module trimmed_weighted_center_of_mass #(
    parameter int MAX_PARTICLES = 1024
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // mass[23:0], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each)
    input  wire  [215:0] s_tdata,
    input  wire          s_tlast,
    output logic         m_tvalid,
    input  wire          m_tready,
    // center pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each), passes_done[4:0]
    output logic [199:0] m_tdata,
    input  wire          cfg_we,
    input  wire          cfg_index,
    input  wire  [16:0]  cfg_data
);

    localparam int IW  = $clog2(MAX_PARTICLES);
    localparam int CW  = $clog2(MAX_PARTICLES + 1);
    localparam int WSW = twcom_pkg::MASS_W + CW;
    localparam int FNW = twcom_pkg::KF_W + CW;

    typedef enum logic [24:0] {
        S_LOAD      = 25'h0000001,
        S_INIT      = 25'h0000002,
        S_M_RD      = 25'h0000004,
        S_M_W       = 25'h0000008,
        S_ACC       = 25'h0000010,
        S_SUMS      = 25'h0000020,
        S_CDIV_GO   = 25'h0000040,
        S_CDIV_WAIT = 25'h0000080,
        S_PASS_END  = 25'h0000100,
        S_DIST_RD   = 25'h0000200,
        S_DIST_SQ   = 25'h0000400,
        S_RANK_RDI  = 25'h0000800,
        S_RANK_LDI  = 25'h0001000,
        S_RANK_JA   = 25'h0002000,
        S_RANK_JC   = 25'h0004000,
        S_RANK_WR   = 25'h0008000,
        S_CUT_RS    = 25'h0010000,
        S_CUT_RD    = 25'h0020000,
        S_CUT_GET   = 25'h0040000,
        S_W_RS      = 25'h0080000,
        S_W_RP      = 25'h0100000,
        S_W_RD      = 25'h0200000,
        S_W_DIV     = 25'h0400000,
        S_W_MUL     = 25'h0800000,
        S_OUT       = 25'h1000000
    } state_t;

    state_t state_reg;

    logic [twcom_pkg::KF_W-1:0] kf_reg;
    logic [twcom_pkg::EP_W-1:0] ep_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] keep_reg;
    logic [IW-1:0] cut_reg;
    logic [CW-1:0] i_reg;
    logic [IW-1:0] j_reg;
    logic [IW-1:0] rank_reg;
    logic [2:0] k_reg;
    logic first_reg;
    logic [twcom_pkg::EP_W-1:0] count_reg;
    logic [twcom_pkg::PASS_W-1:0] passes_reg;
    logic [twcom_pkg::MASS_W-1:0] w_reg;
    logic [WSW-1:0] wsum_reg;
    logic signed [56:0] prod_reg;
    logic signed [twcom_pkg::SUM_W-1:0] sums_reg [twcom_pkg::NCOORD];
    logic [twcom_pkg::COORD_W-1:0] center_reg [twcom_pkg::NCOORD];
    logic neg_reg;
    logic [twcom_pkg::DIST_W-1:0] sq_reg;
    logic [twcom_pkg::DIST_W-1:0] dacc_reg;
    logic [twcom_pkg::DIST_W-1:0] di_reg;
    logic [twcom_pkg::DIST_W-1:0] rc2_reg;
    logic [twcom_pkg::KF_W-1:0] fac_reg;
    logic m_tvalid_reg;
    logic [twcom_pkg::OUT_W-1:0] m_tdata_reg;

    logic [twcom_pkg::DIST_W-1:0] dmem [MAX_PARTICLES];
    logic [IW-1:0] smem [MAX_PARTICLES];
    logic [twcom_pkg::DIST_W-1:0] dmem_q_reg;
    logic [IW-1:0] smem_q_reg;

    logic in_acc;
    logic has_room;
    twcom_pkg::particle_t in_part;
    twcom_pkg::particle_t pq;
    logic pm_rd_en;
    logic [IW-1:0] pm_rd_addr;
    logic dm_rd_en;
    logic [IW-1:0] dm_rd_addr;
    logic sm_rd_en;
    logic [IW-1:0] sm_rd_addr;
    twcom_pkg::div_req_t div_req;
    twcom_pkg::div_rsp_t div_rsp;

    logic [twcom_pkg::KF_W-1:0] f_clamp;
    logic [FNW-1:0] fn;
    logic [FNW:0] keep_w;
    logic [CW-1:0] cut_raw;
    logic [CW-1:0] n_m1;
    logic [CW-1:0] cut_val;
    logic signed [twcom_pkg::COORD_W-1:0] pcoord;
    logic signed [twcom_pkg::COORD_W:0] dpos;
    logic [twcom_pkg::COORD_W:0] dmag;
    logic [twcom_pkg::DIST_W-1:0] dsum;
    logic [40:0] mw;
    logic out_free;
    logic signed [twcom_pkg::SUM_W-1:0] prod_ext;

    assign s_tready = (state_reg == S_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign has_room = cnt_reg < CW'(MAX_PARTICLES);

    assign in_part.particle_mass = s_tdata[23:0];
    assign in_part.pos_x = s_tdata[55:24];
    assign in_part.pos_y = s_tdata[87:56];
    assign in_part.pos_z = s_tdata[119:88];
    assign in_part.vel_x = s_tdata[151:120];
    assign in_part.vel_y = s_tdata[183:152];
    assign in_part.vel_z = s_tdata[215:184];

    twcom_pstore #(
        .DEPTH(MAX_PARTICLES),
        .AW   (IW)
    ) u_pstore (
        .aclk   (aclk),
        .wr_en  (in_acc && has_room),
        .wr_addr(cnt_reg[IW-1:0]),
        .wr_data(in_part),
        .rd_en  (pm_rd_en),
        .rd_addr(pm_rd_addr),
        .rd_data(pq)
    );

    twcom_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    assign f_clamp = (kf_reg > twcom_pkg::KF_ONE) ? twcom_pkg::KF_ONE : kf_reg;
    assign fn      = FNW'(f_clamp) * FNW'(n_reg);
    assign keep_w  = {1'b0, fn} + (FNW + 1)'(16'hFFFF);
    assign cut_raw = CW'(fn >> 16);
    assign n_m1    = n_reg - 1'b1;
    assign cut_val = (cut_raw > n_m1) ? n_m1 : cut_raw;

    assign pcoord = twcom_pkg::coord_sel(pq, k_reg);
    assign dpos = {pcoord[31], pcoord} - {center_reg[k_reg][31], center_reg[k_reg]};
    assign dmag = dpos[twcom_pkg::COORD_W] ? -dpos : dpos;
    assign dsum = twcom_pkg::sat_addu(dacc_reg, sq_reg);
    assign mw   = 41'(pq.particle_mass) * 41'(fac_reg);
    assign prod_ext = {{7{prod_reg[56]}}, prod_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        pm_rd_en   = 1'b0;
        pm_rd_addr = i_reg[IW-1:0];
        dm_rd_en   = 1'b0;
        dm_rd_addr = i_reg[IW-1:0];
        sm_rd_en   = 1'b0;
        sm_rd_addr = i_reg[IW-1:0];
        unique case (state_reg)
            S_M_RD, S_DIST_RD: begin
                pm_rd_en = (i_reg != n_reg);
            end
            S_RANK_RDI: begin
                dm_rd_en = (i_reg != n_reg);
            end
            S_RANK_JA: begin
                dm_rd_en   = 1'b1;
                dm_rd_addr = j_reg;
            end
            S_CUT_RS: begin
                sm_rd_en   = 1'b1;
                sm_rd_addr = cut_reg;
            end
            S_CUT_RD: begin
                dm_rd_en   = 1'b1;
                dm_rd_addr = smem_q_reg;
            end
            S_W_RS: begin
                sm_rd_en = (i_reg != keep_reg);
            end
            S_W_RP: begin
                dm_rd_en   = 1'b1;
                dm_rd_addr = smem_q_reg;
                pm_rd_en   = 1'b1;
                pm_rd_addr = smem_q_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.steps    = twcom_pkg::STEPS_CENTER;
        div_req.rem_init = 64'd0;
        div_req.dividend = sums_reg[k_reg][63] ? -sums_reg[k_reg] : sums_reg[k_reg];
        div_req.divisor  = 64'(wsum_reg);
        if (state_reg == S_CDIV_GO) begin
            div_req.start = 1'b1;
        end else if (state_reg == S_W_RD) begin
            div_req.start    = dmem_q_reg < rc2_reg;
            div_req.steps    = twcom_pkg::STEPS_FRAC;
            div_req.rem_init = dmem_q_reg;
            div_req.dividend = 64'd0;
            div_req.divisor  = rc2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (dm_rd_en) begin
            dmem_q_reg <= dmem[dm_rd_addr];
        end
        if (sm_rd_en) begin
            smem_q_reg <= smem[sm_rd_addr];
        end
        if (state_reg == S_DIST_SQ && k_reg == 3'd3) begin
            dmem[i_reg[IW-1:0]] <= dsum;
        end
        if (state_reg == S_RANK_WR) begin
            smem[rank_reg] <= i_reg[IW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            kf_reg       <= twcom_pkg::KF_RESET;
            ep_reg       <= twcom_pkg::EP_RESET;
        end else begin
            if (cfg_we) begin
                if (cfg_index == twcom_pkg::CFG_KEEP_FRACTION) begin
                    kf_reg <= cfg_data;
                end else begin
                    ep_reg <= cfg_data[twcom_pkg::EP_W-1:0];
                end
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (in_acc) begin
                        if (has_room) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        if (s_tlast) begin
                            n_reg     <= has_room ? cnt_reg + 1'b1 : cnt_reg;
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    keep_reg   <= keep_w[16 +: CW];
                    cut_reg    <= cut_val[IW-1:0];
                    count_reg  <= (f_clamp == twcom_pkg::KF_ONE) ? '0 : ep_reg;
                    first_reg  <= 1'b1;
                    passes_reg <= '0;
                    wsum_reg   <= '0;
                    for (int c = 0; c < twcom_pkg::NCOORD; c++) begin
                        sums_reg[c] <= '0;
                    end
                    i_reg     <= '0;
                    state_reg <= S_M_RD;
                end
                S_M_RD: begin
                    state_reg <= (i_reg == n_reg) ? S_SUMS : S_M_W;
                end
                S_M_W: begin
                    w_reg     <= pq.particle_mass;
                    k_reg     <= '0;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    if (k_reg != 3'd6) begin
                        prod_reg <= $signed({1'b0, w_reg}) * pcoord;
                    end
                    if (k_reg != 3'd0) begin
                        sums_reg[k_reg - 1'b1] <= twcom_pkg::sat_add(sums_reg[k_reg - 1'b1],
                                                                     prod_ext);
                    end
                    if (k_reg == 3'd6) begin
                        wsum_reg  <= wsum_reg + WSW'(w_reg);
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= first_reg ? S_M_RD : S_W_RS;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_SUMS: begin
                    k_reg <= '0;
                    i_reg <= '0;
                    if (wsum_reg != '0) begin
                        state_reg <= S_CDIV_GO;
                    end else if (first_reg) begin
                        for (int c = 0; c < twcom_pkg::NCOORD; c++) begin
                            center_reg[c] <= '0;
                        end
                        state_reg <= S_DIST_RD;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_CDIV_GO: begin
                    neg_reg   <= sums_reg[k_reg][63];
                    state_reg <= S_CDIV_WAIT;
                end
                S_CDIV_WAIT: begin
                    if (div_rsp.done) begin
                        center_reg[k_reg] <= twcom_pkg::sat32(neg_reg, div_rsp.quo);
                        if (k_reg == 3'd5) begin
                            i_reg     <= '0;
                            state_reg <= first_reg ? S_DIST_RD : S_PASS_END;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_CDIV_GO;
                        end
                    end
                end
                S_PASS_END: begin
                    passes_reg <= passes_reg + 1'b1;
                    i_reg      <= '0;
                    if (count_reg == '0) begin
                        state_reg <= S_OUT;
                    end else begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DIST_RD;
                    end
                end
                S_DIST_RD: begin
                    first_reg <= 1'b0;
                    k_reg     <= '0;
                    dacc_reg  <= '0;
                    if (i_reg == n_reg) begin
                        i_reg     <= '0;
                        state_reg <= S_RANK_RDI;
                    end else begin
                        state_reg <= S_DIST_SQ;
                    end
                end
                S_DIST_SQ: begin
                    if (k_reg != 3'd3) begin
                        sq_reg <= 64'(dmag[31:0]) * 64'(dmag[31:0]);
                    end
                    if (k_reg != 3'd0) begin
                        dacc_reg <= dsum;
                    end
                    if (k_reg == 3'd3) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_DIST_RD;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_RANK_RDI: begin
                    if (i_reg == n_reg) begin
                        state_reg <= S_CUT_RS;
                    end else begin
                        state_reg <= S_RANK_LDI;
                    end
                end
                S_RANK_LDI: begin
                    di_reg    <= dmem_q_reg;
                    j_reg     <= '0;
                    rank_reg  <= '0;
                    state_reg <= S_RANK_JA;
                end
                S_RANK_JA: begin
                    state_reg <= S_RANK_JC;
                end
                S_RANK_JC: begin
                    if (dmem_q_reg < di_reg || (dmem_q_reg == di_reg && CW'(j_reg) < i_reg)) begin
                        rank_reg <= rank_reg + 1'b1;
                    end
                    if (CW'(j_reg) == n_m1) begin
                        state_reg <= S_RANK_WR;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_RANK_JA;
                    end
                end
                S_RANK_WR: begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_RANK_RDI;
                end
                S_CUT_RS: begin
                    state_reg <= S_CUT_RD;
                end
                S_CUT_RD: begin
                    state_reg <= S_CUT_GET;
                end
                S_CUT_GET: begin
                    rc2_reg  <= dmem_q_reg;
                    wsum_reg <= '0;
                    for (int c = 0; c < twcom_pkg::NCOORD; c++) begin
                        sums_reg[c] <= '0;
                    end
                    i_reg     <= '0;
                    state_reg <= (dmem_q_reg == '0) ? S_SUMS : S_W_RS;
                end
                S_W_RS: begin
                    state_reg <= (i_reg == keep_reg) ? S_SUMS : S_W_RP;
                end
                S_W_RP: begin
                    state_reg <= S_W_RD;
                end
                S_W_RD: begin
                    if (dmem_q_reg < rc2_reg) begin
                        state_reg <= S_W_DIV;
                    end else begin
                        fac_reg   <= '0;
                        state_reg <= S_W_MUL;
                    end
                end
                S_W_DIV: begin
                    if (div_rsp.done) begin
                        fac_reg   <= twcom_pkg::KF_ONE - {1'b0, div_rsp.quo[15:0]};
                        state_reg <= S_W_MUL;
                    end
                end
                S_W_MUL: begin
                    w_reg     <= mw[39:16];
                    k_reg     <= '0;
                    state_reg <= S_ACC;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {3'b000, passes_reg,
                                         center_reg[5], center_reg[4], center_reg[3],
                                         center_reg[2], center_reg[1], center_reg[0]};
                        m_tvalid_reg <= 1'b1;
                        cnt_reg      <= '0;
                        state_reg    <= S_LOAD;
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_PARTICLES))
        else $error("Loaded count exceeds the store depth.");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> (state_reg == S_W_DIV || state_reg == S_CDIV_WAIT))
        else $error("Divider runs while no state waits for it.");

    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RANK_WR |-> CW'(rank_reg) < n_reg)
        else $error("Rank falls outside the loaded set.");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free) |=> (m_tvalid && state_reg == S_LOAD && cnt_reg == '0))
        else $error("Finished result was not presented.");
`endif

endmodule
`default_nettype wire
